### sv/assert_macros.svh
// Assertion helpers for the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### sv/s36r_pkg.sv
package s36r_pkg;
  localparam int MaxCols    = 128;
  localparam int KernelTaps = 6;
  localparam int Lines      = KernelTaps - 1;
  localparam int RowLimit   = 128;
  localparam int MinSize    = 6;
  localparam int Norm       = 23104;
  localparam int HalfNorm   = 11552;
  localparam logic [0:0] REG_COLS = 1'b0;
  localparam logic [0:0] REG_ROWS = 1'b1;

  // Weights 3,-18,91,91,-18,3 (products 2-D give /23104).
  function automatic logic signed [7:0] tap(input logic [2:0] k);
    case (k)
      3'd0, 3'd5: tap = 8'sd3;
      3'd1, 3'd4: tap = -8'sd18;
      3'd2, 3'd3: tap = 8'sd91;
      default:    tap = 8'sd0;
    endcase
  endfunction

  typedef struct packed {
    logic load;   // capture sample, shift line stores and window
    logic clear;  // clear accumulator
    logic mac;    // accumulate one window row
    logic finish; // never set by the controller and not read by the datapath
    logic emit;   // rounding and output
  } cmd_t;

  typedef struct packed {
    logic produce; // current sample yields a result
  } sts_t;
endpackage

### sv/s36r_stream_if.sv
interface s36r_stream_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/s36r_cfg_if.sv
interface s36r_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

### sv/s36r_ctrl.sv
module s36r_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_full,
  input  s36r_pkg::sts_t sts,
  output s36r_pkg::cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.produce) begin
            cmd.clear  = 1'b1;
            cnt_next   = 3'd0;
            state_next = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (cnt == 3'd5) begin
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_EMIT: begin
        if (!out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.finish = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

### sv/s36r_datapath.sv
`include "assert_macros.svh"
module s36r_datapath #(
  parameter int MAX_COLS = s36r_pkg::MaxCols
) (
  input  logic           clk,
  input  logic           rst,
  input  s36r_pkg::cmd_t cmd,
  output s36r_pkg::sts_t sts,
  input  logic [15:0]    sample,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [15:0]    value,
  output logic [6:0]     out_row,
  output logic [6:0]     out_col,
  output logic           last_of_frame
);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = $clog2(MAX_COLS);
  localparam int T  = s36r_pkg::KernelTaps;
  localparam int L  = s36r_pkg::Lines;
  // 23104 = 64 * 361; ceil(2^35 / 361), exact for quotients of 25-bit inputs
  localparam logic [26:0] RECIP = 27'd95179331;

  logic [7:0] grid_cols, grid_rows;
  logic [CW-1:0] cols_eff;
  logic [7:0] rows_eff;
  logic [CW-1:0] col_count;
  logic [7:0]    row_count;
  logic row_end, frame_end;

  // line memory: one word holds the five older rows of a column
  logic [L*16-1:0] mem [MAX_COLS];
  logic signed [15:0] win [T][T];
  logic signed [15:0] column [T];
  logic [L*16-1:0] rd, wr;
  logic [AW-1:0] rd_addr_next;

  logic signed [39:0] acc;
  logic [2:0] mrow;
  logic pend_last;
  logic [6:0] pend_row, pend_col;
  logic [39:0] mag, mag_rnd;
  logic [51:0] prod;
  logic [16:0] qmag;

  always_comb begin
    if (grid_cols < 8'(s36r_pkg::MinSize)) cols_eff = CW'(s36r_pkg::MinSize);
    else if (int'(grid_cols) > MAX_COLS) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(grid_cols);
    if (grid_rows < 8'(s36r_pkg::MinSize)) rows_eff = 8'(s36r_pkg::MinSize);
    else if (grid_rows > 8'(s36r_pkg::RowLimit)) rows_eff = 8'(s36r_pkg::RowLimit);
    else rows_eff = grid_rows;
  end

  assign row_end   = (col_count + CW'(1) >= cols_eff) || (col_count == '1);
  assign frame_end = row_end && (row_count + 8'd1 >= rows_eff);
  assign sts.produce = (row_count >= 8'(T)) && (col_count >= CW'(T));

  // column word is prefetched at each load from the column the counter
  // moves to, so rd is registered and ready when the next sample arrives
  assign rd_addr_next = row_end ? '0 : col_count[AW-1:0] + AW'(1);

  always_comb begin
    for (int k = 0; k < L; k++) column[k] = rd[k*16 +: 16];
    column[L] = sample;
    for (int k = 0; k < L - 1; k++) wr[k*16 +: 16] = rd[(k+1)*16 +: 16];
    wr[(L-1)*16 +: 16] = sample;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && col_count < CW'(MAX_COLS)) mem[col_count[AW-1:0]] <= wr;
    if (rst) rd <= mem[0];
    else if (cmd.load) rd <= mem[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= 8'd81;
      grid_rows <= 8'd81;
      col_count <= '0;
      row_count <= '0;
      for (int r = 0; r < T; r++)
        for (int c = 0; c < T; c++) win[r][c] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == s36r_pkg::REG_COLS) grid_cols <= cfg_wdata;
        else grid_rows <= cfg_wdata;
      end
      if (cmd.load) begin
        for (int r = 0; r < T; r++) begin
          for (int c = 0; c < T - 1; c++) win[r][c] <= win[r][c+1];
          win[r][T-1] <= column[r];
        end
        if (row_end) begin
          col_count <= '0;
          row_count <= frame_end ? 8'd0 : row_count + 8'd1;
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
    end
  end

  // one window row per cycle: six products then row weight
  logic signed [31:0] rsum;
  logic signed [39:0] term;
  always_comb begin
    rsum = '0;
    for (int c = 0; c < T; c++)
      rsum = rsum + 32'(s36r_pkg::tap(3'(c))) * 32'(win[mrow][c]);
    term = 40'(rsum) * 40'(s36r_pkg::tap(mrow));
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc       <= '0;
      mrow      <= '0;
      pend_row  <= 7'(row_count - 8'd3);
      pend_col  <= 7'(col_count - CW'(3));
      pend_last <= frame_end;
    end else if (cmd.mac) begin
      acc  <= acc + term;
      mrow <= mrow + 3'd1;
    end
  end

  // magnitude rounded half up, then /64 by shift and /361 by reciprocal
  always_comb begin
    mag     = acc[39] ? 40'(-acc) : 40'(acc);
    mag_rnd = mag + 40'(s36r_pkg::HalfNorm);
    prod    = mag_rnd[30:6] * RECIP;
    qmag    = prod[51:35];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (!acc[39]) begin
        if (qmag > 17'd32767) value <= 16'h7fff;
        else value <= qmag[15:0];
      end else begin
        if (qmag > 17'd32768) value <= 16'h8000;
        else value <= -qmag[15:0];
      end
      out_row       <= pend_row;
      out_col       <= pend_col;
      last_of_frame <= pend_last;
    end
  end

  `ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid)
  `ASSERT_IMPLIES(a_no_overlap, clk, rst, cmd.emit, !(out_valid && !out_ready))
  `ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1, !(cmd.load && cmd.mac))
endmodule

### sv/spline36_half_offset_resampler.sv
// Spline36 half-offset resampler. Raster samples (signed Q3.12) enter one
// transaction at a time; a line memory of MAX_COLS words holds the five
// previous rows of each column and a 6x6 window slides along the row. From
// row 6 and column 6 onwards each sample produces one result: the value at
// grid point (row-3, col-3) shifted half a step in both axes, weights
// 3,-18,91,91,-18,3 over 152 per axis, rounded half away from zero and
// saturated. A sample with no result leaves the input ready; one with a result
// holds it off for load, six row accumulations of the shared row multiplier
// and output, stalling on a full output. Register writes take effect at once.
module spline36_half_offset_resampler #(
  parameter int MAX_COLS = s36r_pkg::MaxCols
) (
  input logic clk,
  input logic rst,
  s36r_cfg_if.sink    cfg,
  s36r_stream_if.sink in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] value,
  output logic [6:0]  out_row,
  output logic [6:0]  out_col,
  output logic        last_of_frame
);
  s36r_pkg::cmd_t cmd;
  s36r_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  s36r_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_full(out_valid && !out_ready),
    .sts, .cmd
  );

  s36r_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .sample(in_ch.data),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata),
    .out_ready, .out_valid, .value, .out_row, .out_col, .last_of_frame
  );
endmodule

### dv/s36r_scoreboard.sv
`timescale 1ns / 100ps

// Watches the sample, register and result channels, keeps its own copy of
// the line stores and the 6x6 window and compares every result with the
// oldest predicted one.
module s36r_scoreboard (
  input  logic          clk,
  input  logic          rst,
  s36r_cfg_if           cfg,
  s36r_stream_if        in_ch,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [15:0]   value,
  input  logic [6:0]    out_row,
  input  logic [6:0]    out_col,
  input  logic          last_of_frame,
  output int            errors,
  output int            pending,
  output int            results_seen,
  output int            frames_seen
);
  localparam int K  = s36r_pkg::KernelTaps;
  localparam int NL = s36r_pkg::Lines;

  typedef struct packed {
    logic [15:0] value;
    logic [6:0]  row;
    logic [6:0]  col;
    logic        last;
  } point_t;

  localparam int Taps[K] = '{3, -18, 91, 91, -18, 3};

  point_t              expected_points[$];
  logic [7:0]          cols_reg, rows_reg;
  logic signed [15:0]  lines[NL][s36r_pkg::MaxCols];
  logic signed [15:0]  win[K][K];
  int                  col_pos, row_pos;

  assign pending = expected_points.size();

  function automatic int eff_size(input logic [7:0] v);
    if (v < s36r_pkg::MinSize) return s36r_pkg::MinSize;
    if (v > 128) return 128;
    return v;
  endfunction

  function automatic logic [15:0] half_step_value();
    longint acc, q;
    acc = 0;
    for (int r = 0; r < K; r++)
      for (int c = 0; c < K; c++)
        acc += longint'(Taps[r] * Taps[c]) * longint'(win[r][c]);
    if (acc >= 0) q = (acc + s36r_pkg::HalfNorm) / s36r_pkg::Norm;
    else q = -((-acc + s36r_pkg::HalfNorm) / s36r_pkg::Norm);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic predict_sample(input logic [15:0] s);
    logic signed [15:0] column[K];
    int cols, rows;
    bit row_end, frame_end;
    point_t p;
    cols = eff_size(cols_reg);
    rows = eff_size(rows_reg);
    for (int k = 0; k < NL; k++) column[k] = lines[k][col_pos];
    for (int k = 0; k < NL - 1; k++) lines[k][col_pos] = lines[k + 1][col_pos];
    lines[NL - 1][col_pos] = s;
    column[NL] = s;
    for (int k = 0; k < K; k++) begin
      for (int x = 0; x < K - 1; x++) win[k][x] = win[k][x + 1];
      win[k][K - 1] = column[k];
    end
    row_end = (col_pos + 1 >= cols);
    frame_end = row_end && (row_pos + 1 >= rows);
    if (row_pos >= K && col_pos >= K) begin
      p.value = half_step_value();
      p.row = 7'(row_pos - K / 2);
      p.col = 7'(col_pos - K / 2);
      p.last = frame_end;
      expected_points.push_back(p);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      cols_reg = 8'd81;
      rows_reg = 8'd81;
      col_pos = 0;
      row_pos = 0;
      for (int r = 0; r < K; r++)
        for (int c = 0; c < K; c++) win[r][c] = '0;
      for (int k = 0; k < NL; k++)
        for (int c = 0; c < s36r_pkg::MaxCols; c++) lines[k][c] = '0;
      expected_points.delete();
      errors = 0;
      results_seen = 0;
      frames_seen = 0;
    end else begin
      // a sample accepted on the same edge as a write still sees the old size
      if (in_ch.valid && in_ch.ready) predict_sample(in_ch.data);
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == s36r_pkg::REG_COLS) cols_reg = cfg.wdata;
        else rows_reg = cfg.wdata;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (last_of_frame) frames_seen++;
        if (expected_points.size() == 0) begin
          $error("unexpected result: value %0d row %0d col %0d",
                 $signed(value), out_row, out_col);
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (value !== e.value) begin
            $error("value: expected %0d, got %0d", $signed(e.value), $signed(value));
            errors++;
          end
          if (out_row !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, out_row);
            errors++;
          end
          if (out_col !== e.col) begin
            $error("out_col: expected %0d, got %0d", e.col, out_col);
            errors++;
          end
          if (last_of_frame !== e.last) begin
            $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
            errors++;
          end
        end
      end
    end
  end
endmodule

### dv/tb_spline36_half_offset_resampler.sv
`timescale 1ns / 100ps

// Top level: drives samples and register writes, stalls the result side,
// and gives the verdict from the scoreboard's error and pending counts.
module tb_spline36_half_offset_resampler;
  logic clk = 1'b0;
  logic rst = 1'b1;

  s36r_cfg_if       cfg();
  s36r_stream_if #(16) in_ch();

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] value;
  logic [6:0]  out_row, out_col;
  logic        last_of_frame;

  int errors, pending, results_seen, frames_seen;
  int samples_sent = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;

  // period 10 ns
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spline36_half_offset_resampler u_dut (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .out_row(out_row), .out_col(out_col), .last_of_frame(last_of_frame)
  );

  s36r_scoreboard u_sb (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .out_row(out_row), .out_col(out_col), .last_of_frame(last_of_frame),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .frames_seen(frames_seen)
  );

  // Result side: mostly random stalls, some fully open stretches, and one
  // long hold-off while samples are on offer so the block backs up its input.
  always @(posedge clk) begin
    int mode, span;
    if (!rst) begin
      if (!hold_done && results_seen >= 30 && in_ch.valid) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 24);
        repeat (span) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'b0;
            default: out_ready <= ($urandom_range(0, 2) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Samples go out in bursts; valid drops only when a gap starts or on drain.
  task automatic push_sample(input logic [15:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    samples_sent++;
  endtask

  // Wait until every predicted result is back, then let the pipeline settle
  // in case the last transaction produced nothing.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= d;
    @(negedge clk);
    while (!cfg.ready) @(negedge clk);
    @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame(input int nc, input int nr);
    repeat (nc * nr) push_sample(rand_sample());
  endtask

  // Frame of 7x7: only (6,6) produces a result, from window rows/cols 1..6.
  // sign_mode 0: all = fill; 1: sign follows the tap product, scaled by fill.
  task automatic directed_frame(input logic [15:0] fill, input bit sign_mode);
    int tr, tc;
    logic [15:0] s;
    for (int r = 0; r < 7; r++)
      for (int c = 0; c < 7; c++) begin
        s = fill;
        if (sign_mode && r > 0 && c > 0) begin
          tr = r - 1;
          tc = c - 1;
          // taps 1 and 4 are the negative ones
          if (((tr == 1) || (tr == 4)) != ((tc == 1) || (tc == 4))) s = ~fill + 16'd1;
          if (fill == 16'h8000 && s == 16'h8000 &&
              (((tr == 1) || (tr == 4)) != ((tc == 1) || (tc == 4)))) s = 16'h7FFF;
        end
        push_sample(s);
      end
  endtask

  initial begin
    int random_start;
    cfg.valid = 1'b0;
    cfg.index = s36r_pkg::REG_COLS;
    cfg.wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: flat extremes, sign-matched patterns for saturation
    write_reg(s36r_pkg::REG_COLS, 8'd7);
    write_reg(s36r_pkg::REG_ROWS, 8'd7);
    directed_frame(16'h7FFF, 1'b0);
    directed_frame(16'h8000, 1'b0);
    directed_frame(16'h0000, 1'b0);
    directed_frame(16'h7FFF, 1'b1);
    directed_frame(16'h8000, 1'b1);
    drain();

    // Sizes below the minimum clamp to 6: no results at all
    write_reg(s36r_pkg::REG_COLS, 8'd0);
    write_reg(s36r_pkg::REG_ROWS, 8'd5);
    random_frame(6, 6);
    drain();

    // Oversized column count clamps to 128: the first row ends after 128
    // samples, then narrow rows finish the frame with one result
    write_reg(s36r_pkg::REG_COLS, 8'd255);
    write_reg(s36r_pkg::REG_ROWS, 8'd7);
    random_frame(128, 1);
    drain();
    write_reg(s36r_pkg::REG_COLS, 8'd7);
    random_frame(7, 6);
    drain();

    // Row count mid-frame: shrink below the current row, next row ends it
    write_reg(s36r_pkg::REG_COLS, 8'd9);
    write_reg(s36r_pkg::REG_ROWS, 8'd12);
    random_frame(9, 9);
    drain();
    write_reg(s36r_pkg::REG_ROWS, 8'd6);
    random_frame(9, 1);
    drain();

    // Column count mid-row: counter already past the new last column
    write_reg(s36r_pkg::REG_COLS, 8'd20);
    random_frame(12, 1);
    drain();
    write_reg(s36r_pkg::REG_COLS, 8'd6);
    push_sample(rand_sample());
    random_frame(6, 5);
    drain();

    // Random frames, small sizes
    random_start = samples_sent;
    while (samples_sent - random_start < 320) begin
      int nc, nr;
      nc = $urandom_range(7, 16);
      nr = $urandom_range(7, 10);
      write_reg(s36r_pkg::REG_COLS, 8'(nc));
      write_reg(s36r_pkg::REG_ROWS, 8'(nr));
      random_frame(nc, nr);
      drain();
    end

    $display("%0d samples sent, %0d results checked over %0d frames",
             samples_sent, results_seen, frames_seen);
    $display("covered size clamping, mid-frame resizing, saturation and stalls");
    if (errors == 0 && pending == 0) begin
      $display("tb_spline36_half_offset_resampler passed");
    end else begin
      $display("tb_spline36_half_offset_resampler failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_spline36_half_offset_resampler failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/s36r_pkg.sv
sv/s36r_stream_if.sv
sv/s36r_cfg_if.sv
sv/s36r_ctrl.sv
sv/s36r_datapath.sv
sv/spline36_half_offset_resampler.sv
dv/s36r_scoreboard.sv
dv/tb_spline36_half_offset_resampler.sv
